// ----- rtl/pgpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgpc_pkg: shared types and constants
// sizes, request codes and the transaction formats passed between front and back
// ----------------------------------------------------------------------------
package pgpc_pkg;

	// array geometry
	localparam int ROWS        = 512;
	localparam int COLS        = 1024;
	localparam int GAIN_LEVELS = 3;
	localparam int SUM_DEPTH   = ROWS * COLS;
	localparam int CAL_DEPTH   = GAIN_LEVELS * SUM_DEPTH;
	localparam int PIX_AW      = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
	localparam int CAL_AW      = (CAL_DEPTH > 1) ? $clog2(CAL_DEPTH) : 1;

	// field widths
	localparam int REQ_W  = 2;
	localparam int ROW_W  = 9;
	localparam int COL_W  = 10;
	localparam int RAW_W  = 16;
	localparam int ADC_W  = 14;
	localparam int GSEL_W = 2;
	localparam int DATA_W = 32;
	localparam int FRAC_W = 6;
	localparam int PED_W  = ADC_W + FRAC_W;
	localparam int PED_MAX = (2 ** PED_W) - 1;

	localparam logic signed [DATA_W-1:0] THRESHOLD_RESET = DATA_W'(-5000 * 64);

	// request codes
	localparam logic [REQ_W-1:0] REQ_SAMPLE     = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOAD_PED   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_LOAD_GAIN  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_READ_CLEAR = 2'd3;

	// gain codes in the raw word
	localparam logic [1:0] GCODE_BAD  = 2'd2;
	localparam logic [1:0] GCODE_HIGH = 2'd3;
	localparam logic [1:0] PLANE_HIGH = 2'd2;

	// queue sizes
	localparam int MID_DEPTH = 4;
	localparam int MID_PW    = $clog2(MID_DEPTH);
	localparam int OUT_DEPTH = 8;
	localparam int OUT_PW    = $clog2(OUT_DEPTH);

	// classified transaction, front to back
	typedef struct packed {
		logic [REQ_W-1:0]  kind;
		logic              addr_ok;
		logic              cal_ok;
		logic [PIX_AW-1:0] pix;
		logic [CAL_AW-1:0] cal_addr;
		logic [ADC_W-1:0]  adc;
		logic [1:0]        gidx;
		logic              bad;
		logic [DATA_W-1:0] wval;
	} item_t;

	// result transaction
	typedef struct packed {
		logic signed [DATA_W-1:0] energy;
		logic signed [DATA_W-1:0] sum;
		logic                     above;
		logic [1:0]               gidx;
		logic                     bad;
	} result_t;

	// back status seen by the top level
	typedef struct packed {
		logic            clearing;
		logic [OUT_PW:0] out_count;
	} back_stat_t;

endpackage

// ----- rtl/pgpc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgpc_ram: generic single-write, single-read memory
// one write port, one read port with registered read data (old data on collision)
// ----------------------------------------------------------------------------
module pgpc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/pgpc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgpc_front: request classification and decoupling queue
// decodes address, gain plane and load value, then queues the transaction
// ----------------------------------------------------------------------------
module pgpc_front
	import pgpc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_en,
	output logic                     q_full,
	input  logic [REQ_W-1:0]         req_type,
	input  logic [ROW_W-1:0]         pixel_row,
	input  logic [COL_W-1:0]         pixel_col,
	input  logic [RAW_W-1:0]         raw_sample,
	input  logic [GSEL_W-1:0]        gain_select,
	input  logic signed [DATA_W-1:0] load_value,
	output logic                     item_valid,
	output item_t                    item,
	input  logic                     item_pop
);

	item_t             cls;
	logic [1:0]        code;
	logic [1:0]        dec;
	logic [1:0]        plane;
	logic              dec_bad;
	logic              accept;

	item_t             mem_q [MID_DEPTH];
	logic [MID_PW-1:0] wr_ptr_q;
	logic [MID_PW-1:0] rd_ptr_q;
	logic [MID_PW:0]   count_q;

	always_comb begin
		code    = raw_sample[RAW_W-1 -: 2];
		dec     = (code == GCODE_HIGH) ? PLANE_HIGH : ((code == GCODE_BAD) ? 2'd0 : code);
		dec_bad = (code == GCODE_BAD) || !(32'(dec) < GAIN_LEVELS);

		cls.kind    = req_type;
		cls.addr_ok = (32'(pixel_row) < ROWS) && (32'(pixel_col) < COLS);
		cls.pix     = PIX_AW'(32'(pixel_row) * COLS + 32'(pixel_col));
		cls.adc     = raw_sample[ADC_W-1:0];
		cls.gidx    = 2'd0;
		cls.bad     = 1'b0;
		cls.cal_ok  = 1'b0;
		plane       = gain_select;
		case (req_type)
			REQ_SAMPLE: begin
				plane      = dec;
				cls.gidx   = dec;
				cls.bad    = dec_bad;
				cls.cal_ok = !dec_bad;
			end
			REQ_LOAD_PED, REQ_LOAD_GAIN: begin
				cls.cal_ok = 32'(gain_select) < GAIN_LEVELS;
			end
			default: begin
				cls.cal_ok = 1'b0;
			end
		endcase
		cls.cal_addr = CAL_AW'(32'(plane) * SUM_DEPTH + 32'(cls.pix));

		// pedestal clamps to the unsigned pedestal range
		if (req_type == REQ_LOAD_PED) begin
			if (load_value[DATA_W-1]) begin
				cls.wval = '0;
			end else if (load_value > PED_MAX) begin
				cls.wval = DATA_W'(PED_MAX);
			end else begin
				cls.wval = load_value;
			end
		end else begin
			cls.wval = load_value;
		end
	end

	assign q_full     = (count_q == (MID_PW + 1)'(MID_DEPTH));
	assign accept     = in_en && !q_full;
	assign item_valid = (count_q != '0);
	assign item       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (item_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({accept, item_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/pgpc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgpc_back: calibration, energy and per-pixel sum pipeline
// calibration memories, multiply and round, sum read-modify-write, result queue
// ----------------------------------------------------------------------------
module pgpc_back
	import pgpc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	input  item_t                    item,
	output logic                     item_pop,
	input  logic signed [DATA_W-1:0] thr,
	input  logic                     pop,
	output logic                     empty,
	output result_t                  res,
	output back_stat_t               stat
);

	localparam int DIFF_W = PED_W + 1;
	localparam int PROD_W = DIFF_W + DATA_W;

	typedef struct packed {
		logic [REQ_W-1:0]  kind;
		logic              addr_ok;
		logic              cal_ok;
		logic [PIX_AW-1:0] pix;
		logic [1:0]        gidx;
		logic              bad;
	} tag_t;

	function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
		logic signed [DATA_W-1:0] r;
		if (v[DATA_W] != v[DATA_W-1]) begin
			r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	// issue and credit
	logic              issue;
	logic              pop_acc;
	logic [OUT_PW:0]   reserved_q;

	// clearing pass
	logic              clr_active_q;
	logic [PIX_AW-1:0] clr_cnt_q;

	// pipeline
	logic                     v_s1, v_s2, v_s3, v_s4;
	tag_t                     tag_s1, tag_s2, tag_s3, tag_s4;
	logic [ADC_W-1:0]         adc_s1;
	logic [PED_W-1:0]         ped_rd;
	logic [DATA_W-1:0]        inv_rd;
	logic signed [DIFF_W-1:0] diff_s2;
	logic signed [DATA_W-1:0] inv_s2;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [PROD_W-1:0] rnd;
	logic signed [DATA_W-1:0] energy_s4;
	logic [DATA_W-1:0]        sum_rd;

	// sum update
	logic signed [DATA_W-1:0] old_sum;
	logic signed [DATA_W-1:0] new_sum;
	logic                     above;
	logic                     sum_we;
	logic [PIX_AW-1:0]        sum_waddr;
	logic [DATA_W-1:0]        sum_wdata;
	logic                     fwd_valid_q;
	logic [PIX_AW-1:0]        fwd_pix_q;
	logic signed [DATA_W-1:0] fwd_data_q;
	result_t                  res_s4;

	// result queue
	result_t           out_mem_q [OUT_DEPTH];
	logic [OUT_PW-1:0] out_wr_q;
	logic [OUT_PW-1:0] out_rd_q;
	logic [OUT_PW:0]   out_count_q;

	assign issue    = item_valid && !clr_active_q && (reserved_q < (OUT_PW + 1)'(OUT_DEPTH));
	assign item_pop = issue;
	assign empty    = (out_count_q == '0);
	assign pop_acc  = pop && !empty;
	assign res      = out_mem_q[out_rd_q];

	assign stat.clearing  = clr_active_q;
	assign stat.out_count = out_count_q;

	// calibration writes happen at issue, so the next transaction reads them
	pgpc_ram #(.WIDTH(PED_W), .DEPTH(CAL_DEPTH)) u_ped_ram (
		.clk   (clk),
		.we    (issue && item.addr_ok && item.cal_ok && (item.kind == REQ_LOAD_PED)),
		.waddr (item.cal_addr),
		.wdata (item.wval[PED_W-1:0]),
		.raddr (item.cal_addr),
		.rdata (ped_rd)
	);

	pgpc_ram #(.WIDTH(DATA_W), .DEPTH(CAL_DEPTH)) u_inv_ram (
		.clk   (clk),
		.we    (issue && item.addr_ok && item.cal_ok && (item.kind == REQ_LOAD_GAIN)),
		.waddr (item.cal_addr),
		.wdata (item.wval),
		.raddr (item.cal_addr),
		.rdata (inv_rd)
	);

	pgpc_ram #(.WIDTH(DATA_W), .DEPTH(SUM_DEPTH)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (tag_s3.pix),
		.rdata (sum_rd)
	);

	assign prod = PROD_W'(diff_s2) * PROD_W'(inv_s2);
	assign rnd  = prod_s3 + (PROD_W'(1) <<< 19);

	// sum read-modify-write with forwarding of last cycle's write
	always_comb begin
		old_sum = (fwd_valid_q && (fwd_pix_q == tag_s4.pix)) ? fwd_data_q : sum_rd;
		above   = (tag_s4.kind == REQ_SAMPLE) && tag_s4.addr_ok && tag_s4.cal_ok &&
		          (energy_s4 > thr);
		new_sum = sat33((DATA_W + 1)'(old_sum) + (DATA_W + 1)'(energy_s4));

		if (clr_active_q) begin
			sum_we    = 1'b1;
			sum_waddr = clr_cnt_q;
			sum_wdata = '0;
		end else begin
			sum_we    = v_s4 && tag_s4.addr_ok &&
			            (above || (tag_s4.kind == REQ_READ_CLEAR));
			sum_waddr = tag_s4.pix;
			sum_wdata = above ? new_sum : '0;
		end

		res_s4 = '0;
		if (tag_s4.addr_ok) begin
			res_s4.energy = ((tag_s4.kind == REQ_SAMPLE) && tag_s4.cal_ok) ? energy_s4 : '0;
			res_s4.sum    = above ? new_sum : old_sum;
			res_s4.above  = above;
			res_s4.gidx   = tag_s4.gidx;
			res_s4.bad    = tag_s4.bad;
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		tag_s1    <= '{kind: item.kind, addr_ok: item.addr_ok, cal_ok: item.cal_ok,
		              pix: item.pix, gidx: item.gidx, bad: item.bad};
		adc_s1    <= item.adc;
		tag_s2    <= tag_s1;
		diff_s2   <= $signed({1'b0, adc_s1, {FRAC_W{1'b0}}}) - $signed({1'b0, ped_rd});
		inv_s2    <= inv_rd;
		tag_s3    <= tag_s2;
		prod_s3   <= prod;
		tag_s4    <= tag_s3;
		energy_s4 <= sat33(rnd[PROD_W-1:20]);
		fwd_pix_q  <= sum_waddr;
		fwd_data_q <= sum_wdata;
		if (v_s4) begin
			out_mem_q[out_wr_q] <= res_s4;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			fwd_valid_q  <= 1'b0;
			clr_active_q <= 1'b1;
			clr_cnt_q    <= '0;
			reserved_q   <= '0;
			out_wr_q     <= '0;
			out_rd_q     <= '0;
			out_count_q  <= '0;
		end else begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			fwd_valid_q <= sum_we && !clr_active_q;

			if (clr_active_q) begin
				if (clr_cnt_q == PIX_AW'(SUM_DEPTH - 1)) begin
					clr_active_q <= 1'b0;
				end else begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
				end
			end

			case ({issue, pop_acc})
				2'b10:   reserved_q <= reserved_q + 1'b1;
				2'b01:   reserved_q <= reserved_q - 1'b1;
				default: reserved_q <= reserved_q;
			endcase

			if (v_s4) begin
				out_wr_q <= out_wr_q + 1'b1;
			end
			if (pop_acc) begin
				out_rd_q <= out_rd_q + 1'b1;
			end
			case ({v_s4, pop_acc})
				2'b10:   out_count_q <= out_count_q + 1'b1;
				2'b01:   out_count_q <= out_count_q - 1'b1;
				default: out_count_q <= out_count_q;
			endcase
		end
	end

endmodule

// ----- rtl/pixel_gain_pedestal_correct_sum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_gain_pedestal_correct_sum: detector pixel correction and summing
// throughput: one transaction per cycle while requests wait in the front queue
//   and the result queue has credit, set by the sum memory read-modify-write
//   (separate read and write ports) with write forwarding
// reset: threshold returns to -5000.0; a clearing pass zeroes all ROWS*COLS
//   (524288) sums, full stays high meanwhile
// ----------------------------------------------------------------------------
module pixel_gain_pedestal_correct_sum
	import pgpc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// request side
	input  logic                     push,
	output logic                     full,
	input  logic [REQ_W-1:0]         req_type,
	input  logic [ROW_W-1:0]         pixel_row,
	input  logic [COL_W-1:0]         pixel_col,
	input  logic [RAW_W-1:0]         raw_sample,
	input  logic [GSEL_W-1:0]        gain_select,
	input  logic signed [DATA_W-1:0] load_value,
	// result side
	output logic                     empty,
	input  logic                     pop,
	output logic signed [DATA_W-1:0] energy,
	output logic signed [DATA_W-1:0] pixel_sum,
	output logic                     above_threshold,
	output logic [1:0]               gain_index,
	output logic                     bad_gain,
	// threshold register
	input  logic                     cfg_wr_en,
	input  logic signed [DATA_W-1:0] cfg_wr_data
);

	// threshold register, signed with 6 fraction bits
	logic signed [DATA_W-1:0] thr_q;

	// front to back transaction channel
	logic       q_full;
	logic       item_valid;
	item_t      item;
	logic       item_pop;

	result_t    res;
	back_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// no requests while the sum memory is being cleared
	assign full = q_full || stat.clearing;

	// front: decode address and gain plane, clamp pedestals, queue
	pgpc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_en       (push && !stat.clearing),
		.q_full      (q_full),
		.req_type    (req_type),
		.pixel_row   (pixel_row),
		.pixel_col   (pixel_col),
		.raw_sample  (raw_sample),
		.gain_select (gain_select),
		.load_value  (load_value),
		.item_valid  (item_valid),
		.item        (item),
		.item_pop    (item_pop)
	);

	// back: calibration lookup, multiply, round, threshold and sum update
	pgpc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.thr        (thr_q),
		.pop        (pop),
		.empty      (empty),
		.res        (res),
		.stat       (stat)
	);

	// result ports show the head of the result queue
	assign energy          = res.energy;
	assign pixel_sum       = res.sum;
	assign above_threshold = res.above;
	assign gain_index      = res.gidx;
	assign bad_gain        = res.bad;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------

	// clearing pass must hold off all requests
	a_full_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> full)
		else $error("request side open during sum clearing");

	// credit scheme keeps the result queue from overflowing
	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.out_count <= (OUT_PW + 1)'(OUT_DEPTH))
		else $error("result queue overflow");

	// a skipped sample never carries energy or updates the sum
	a_bad_gain_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && bad_gain) |-> ((energy == '0) && !above_threshold))
		else $error("bad gain sample with energy or summed");

	// no result can appear before the clearing pass finished
	a_no_result_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> empty)
		else $error("result present during sum clearing");

endmodule
